@@ rtl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types, character codes and the byte keep rule for the comment stripper
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

   localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
   localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] PRINT_MIN  = 8'd32;
   localparam logic [7:0] END_BYTE   = 8'h00;

   // hold lengths
   localparam logic [1:0] OPEN_HOLD_LAST  = 2'd3;
   localparam logic [1:0] CLOSE_HOLD_LAST = 2'd2;

   typedef struct packed {
      logic       keep;
      logic [7:0] value;
   } keep_type;

   // one run of up to four output beats caused by a single input beat
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            eos;
   } run_type;

   // queue side of the front/back split
   typedef struct packed {
      logic    push;
      run_type run;
   } push_type;

   function automatic keep_type keep_byte(input logic [7:0] b);
      keep_type k;
      k.keep  = 1'b0;
      k.value = b;
      if (b >= PRINT_MIN) begin
         k.keep = 1'b1;
      end else if (b == CHAR_CR || b == CHAR_LF) begin
         k.keep  = 1'b1;
         k.value = CHAR_SPACE;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mcs_front.sv @@
// ----------------------------------------------------------------------------
// mcs_front
// accepts raw bytes, tracks comment and hold state, emits at most one run per beat
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_eos,
   input  wire logic              queue_full,
   output      mcs_pkg::push_type push_out
);

   logic       in_comment_ff, in_comment_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_ff [0:2];
   logic [7:0] held_in [0:2];

   mcs_pkg::keep_type kp;
   logic              accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign kp       = mcs_pkg::keep_byte(in_byte);

   always_comb begin
      in_comment_in = in_comment_ff;
      held_count_in = held_count_ff;
      for (int i = 0; i < 3; i++) begin
         held_in[i] = held_ff[i];
      end
      push_out.push          = 1'b0;
      push_out.run.bytes     = '0;
      push_out.run.last_idx  = '0;
      push_out.run.eos       = 1'b0;

      if (in_eos) begin
         // flush held bytes outside a comment, then the end marker
         push_out.push    = 1'b1;
         push_out.run.eos = 1'b1;
         if (!in_comment_ff) begin
            for (int i = 0; i < 3; i++) begin
               push_out.run.bytes[i] = held_ff[i];
            end
            push_out.run.bytes[held_count_ff] = mcs_pkg::END_BYTE;
            push_out.run.last_idx             = held_count_ff;
         end
         in_comment_in = 1'b0;
         held_count_in = '0;
      end else if (!in_comment_ff) begin
         if (held_count_ff == '0) begin
            if (in_byte == mcs_pkg::CHAR_LT) begin
               held_in[0]    = mcs_pkg::CHAR_LT;
               held_count_in = 2'd1;
            end else if (kp.keep) begin
               push_out.push         = 1'b1;
               push_out.run.bytes[0] = kp.value;
            end
         end else if (kp.keep) begin
            if (held_count_ff != mcs_pkg::OPEN_HOLD_LAST) begin
               held_in[held_count_ff] = kp.value;
               held_count_in          = held_count_ff + 2'd1;
            end else begin
               if (held_ff[0] == mcs_pkg::CHAR_LT && held_ff[1] == mcs_pkg::CHAR_BANG &&
                   held_ff[2] == mcs_pkg::CHAR_DASH && kp.value == mcs_pkg::CHAR_DASH) begin
                  in_comment_in = 1'b1;
               end else begin
                  push_out.push         = 1'b1;
                  push_out.run.bytes[0] = held_ff[0];
                  push_out.run.bytes[1] = held_ff[1];
                  push_out.run.bytes[2] = held_ff[2];
                  push_out.run.bytes[3] = kp.value;
                  push_out.run.last_idx = 2'd3;
               end
               held_count_in = '0;
            end
         end
      end else begin
         // inside a comment: only the close check matters
         if (held_count_ff == '0) begin
            if (in_byte == mcs_pkg::CHAR_DASH) begin
               held_in[0]    = mcs_pkg::CHAR_DASH;
               held_count_in = 2'd1;
            end
         end else if (kp.keep) begin
            if (held_count_ff != mcs_pkg::CLOSE_HOLD_LAST) begin
               held_in[1]    = kp.value;
               held_count_in = 2'd2;
            end else begin
               if (held_ff[0] == mcs_pkg::CHAR_DASH && held_ff[1] == mcs_pkg::CHAR_DASH &&
                   kp.value == mcs_pkg::CHAR_GT) begin
                  in_comment_in = 1'b0;
               end
               held_count_in = '0;
            end
         end
      end

      if (!accept) begin
         push_out.push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         held_count_ff <= '0;
      end else if (accept) begin
         in_comment_ff <= in_comment_in;
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/mcs_queue.sv @@
// ----------------------------------------------------------------------------
// mcs_queue
// short fifo of runs between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_queue #(
   parameter int Depth = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mcs_pkg::push_type push_in,
   output      logic              full,
   output      logic              not_empty,
   output      mcs_pkg::run_type  head_run,
   input  wire logic              pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   mcs_pkg::run_type slot_ff [0:Depth-1];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign head_run  = slot_ff[rd_ptr_ff];
   assign do_push   = push_in.push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.run;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mcs_back.sv @@
// ----------------------------------------------------------------------------
// mcs_back
// unpacks queued runs into output beats, one per cycle while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             run_valid,
   input  wire mcs_pkg::run_type run_in,
   output      logic             run_pop,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [7:0]       out_byte,
   output      logic             out_end,
   output      logic             out_last
);

   logic             busy_ff, busy_in;
   logic [1:0]       idx_ff, idx_in;
   mcs_pkg::run_type run_ff;
   logic             beat_done, run_done, load;

   assign beat_done = busy_ff && out_ready;
   assign run_done  = beat_done && (idx_ff == run_ff.last_idx);
   assign load      = run_valid && (!busy_ff || run_done);
   assign run_pop   = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (run_done) begin
         busy_in = 1'b0;
      end else if (beat_done) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run_in;
      end
   end

   assign out_valid = busy_ff;
   assign out_byte  = run_ff.bytes[idx_ff];
   assign out_last  = (idx_ff == run_ff.last_idx);
   assign out_end   = run_ff.eos && out_last;

endmodule

`default_nettype wire

@@ rtl/markup_comment_stripper.sv @@
// ----------------------------------------------------------------------------
// markup_comment_stripper
// streaming removal of markup comments from a byte stream
// ----------------------------------------------------------------------------
//
//   channel | direction | tdata          | tuser        | tlast
//   --------+-----------+----------------+--------------+---------------
//   req_    | in        | [7:0] in_byte  | -            | end_of_stream
//   rsp_    | out       | [7:0] out_byte | [0] end_mark | last_of_run
//
// one request beat is taken per cycle while the run queue has room; the
// front handles each beat as it arrives, so the input rate is one beat a
// cycle. each beat gives zero to four response beats, sent one per cycle
// by the back while rsp_tready is high. a run reaches the output through
// the queue write and then the load into the back, both registered.
// reset is synchronous and clears the comment flag, hold count, queue and
// output; either side may stall without losing beats, the queue absorbs it.
// req_tready drops only while the queue holds QUEUE_DEPTH runs.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_comment_stripper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request: raw text
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // end_of_stream
   // response: cleaned text
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] out_byte
   output      logic       rsp_tuser,   // [0] end_marker
   output      logic       rsp_tlast    // last_of_run
);

   mcs_pkg::push_type push;
   mcs_pkg::run_type  head_run;
   logic              queue_full;
   logic              queue_not_empty;
   logic              queue_pop;

   // front: classify the byte, update comment/hold state, build a run
   mcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_eos     (req_tlast),
      .queue_full (queue_full),
      .push_out   (push)
   );

   // decoupling queue, one entry per run
   mcs_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_run  (head_run),
      .pop       (queue_pop)
   );

   // back: serialise runs into response beats
   mcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .run_valid (queue_not_empty),
      .run_in    (head_run),
      .run_pop   (queue_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_end   (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/mcs_checker.sv @@
// ----------------------------------------------------------------------------
// mcs_checker
// port level checks for the comment stripper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // end marker always closes its run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end marker without last");

   // end marker carries a zero byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("end marker with nonzero byte");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // an end of stream beat taken while the output is idle shows output
   // once its run has passed the queue and been loaded into the back
   a_eos_marker: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("end of stream not followed by output");

endmodule

bind markup_comment_stripper mcs_checker u_mcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ tb/sv/mcs_strip_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_strip_checker
// watches both streams of the comment stripper, predicts the cleaned text
// and compares every response beat with the oldest expected one
// ----------------------------------------------------------------------------

module mcs_strip_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_stream
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic       rsp_tuser,   // [0] end_marker
   input  logic       rsp_tlast,   // last_of_run
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] text;
      logic       end_mark;
      logic       run_end;
   } clean_beat_type;

   clean_beat_type expected_text[$];

   // shadow of the stripper state
   logic        in_cmt;
   int unsigned hold_n;
   logic [7:0]  held [3];

   function automatic void queue_byte(input logic [7:0] text, input logic end_mark);
      clean_beat_type beat;
      beat = '{text, end_mark, 1'b0};
      expected_text.insert(expected_text.size(), beat);
   endfunction

   // works out the beats one request beat gives and appends them
   task automatic predict_strip(input logic [7:0] b, input logic eos);
      logic [7:0] kept;
      logic       keep;
      int         first;
      int         i;
      first = expected_text.size();
      keep  = 1'b1;
      kept  = b;
      if (b < mcs_pkg::PRINT_MIN) begin
         keep = (b == mcs_pkg::CHAR_CR) || (b == mcs_pkg::CHAR_LF);
         kept = mcs_pkg::CHAR_SPACE;
      end
      if (eos) begin
         if (!in_cmt) begin
            for (i = 0; i < hold_n; i++) queue_byte(held[i], 1'b0);
         end
         queue_byte(mcs_pkg::END_BYTE, 1'b1);
         in_cmt = 1'b0;
         hold_n = 0;
      end else if (!in_cmt) begin
         if (hold_n == 0) begin
            if (b == mcs_pkg::CHAR_LT) begin
               held[0] = mcs_pkg::CHAR_LT;
               hold_n  = 1;
            end else if (keep) begin
               queue_byte(kept, 1'b0);
            end
         end else if (keep) begin
            if (hold_n < 3) begin
               held[hold_n] = kept;
               hold_n++;
            end else begin
               if (held[0] == mcs_pkg::CHAR_LT && held[1] == mcs_pkg::CHAR_BANG &&
                   held[2] == mcs_pkg::CHAR_DASH && kept == mcs_pkg::CHAR_DASH) begin
                  in_cmt = 1'b1;
               end else begin
                  for (i = 0; i < 3; i++) queue_byte(held[i], 1'b0);
                  queue_byte(kept, 1'b0);
               end
               hold_n = 0;
            end
         end
      end else begin
         if (hold_n == 0) begin
            if (b == mcs_pkg::CHAR_DASH) begin
               held[0] = mcs_pkg::CHAR_DASH;
               hold_n  = 1;
            end
         end else if (keep) begin
            if (hold_n < 2) begin
               held[1] = kept;
               hold_n  = 2;
            end else begin
               if (held[0] == mcs_pkg::CHAR_DASH && held[1] == mcs_pkg::CHAR_DASH &&
                   kept == mcs_pkg::CHAR_GT) begin
                  in_cmt = 1'b0;
               end
               hold_n = 0;
            end
         end
      end
      if (expected_text.size() > first) expected_text[$].run_end = 1'b1;
   endtask

   // request first, so a beat caused in the same cycle is already waiting
   always @(posedge clock) begin : check_beats
      clean_beat_type want;
      if (reset) begin
         expected_text.delete();
         in_cmt         = 1'b0;
         hold_n         = 0;
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) predict_strip(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("out_byte: expected none, got %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.text) begin
                  $error("out_byte: expected %h, got %h", want.text, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.end_mark) begin
                  $error("end_marker: expected %b, got %b", want.end_mark, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("last_of_run: expected %b, got %b", want.run_end, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = expected_text.size();
   end

endmodule

@@ tb/sv/tb_markup_comment_stripper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markup_comment_stripper
// drives markup text through the comment stripper under varying back
// pressure; a separate checker predicts and compares the cleaned stream
// ----------------------------------------------------------------------------

module tb_markup_comment_stripper;

   localparam int ITEM_TARGET     = 210;
   localparam int IDLE_LIMIT      = 1000;  // cycles with no beat on either side
   localparam int HOLD_OFF_CYCLES = 60;    // long receiver hold-off, fills the run queue
   localparam int DRAIN_CYCLES    = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } text_beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;   // [7:0] in_byte
   logic          req_tlast;   // end_of_stream
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [7:0]    rsp_tdata;   // [7:0] out_byte
   logic          rsp_tuser;   // [0] end_marker
   logic          rsp_tlast;   // last_of_run

   int            mismatch_n;
   int            pending_n;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            hold_off_req;
   int            idle_cycles;
   text_beat_type text_q[$];

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   markup_comment_stripper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mcs_strip_checker strip_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_n),
      .pending_count  (pending_n)
   );

   // watchdog: a run that stops moving is a failure
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_markup_comment_stripper: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      bit hold_off_done;
      hold_off_done = 1'b0;
      rsp_tready    = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   function automatic void push_text(input logic [7:0] ch, input logic eos);
      text_beat_type beat;
      beat = '{ch, eos};
      text_q.insert(text_q.size(), beat);
   endfunction

   // byte mix for comment bodies: dashes and brackets often, so that close
   // checks open, fail and succeed in every order
   function automatic logic [7:0] comment_byte();
      case ($urandom_range(0, 5))
         0:       return mcs_pkg::CHAR_DASH;
         1:       return mcs_pkg::CHAR_GT;
         2:       return mcs_pkg::CHAR_LT;
         3:       return 8'($urandom_range(0, 31));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // bytes that may or may not continue an opening "<!--"
   function automatic logic [7:0] near_miss_byte();
      case ($urandom_range(0, 5))
         0:       return mcs_pkg::CHAR_BANG;
         1:       return mcs_pkg::CHAR_DASH;
         2:       return mcs_pkg::CHAR_LT;
         3:       return mcs_pkg::CHAR_CR;
         4:       return 8'h01;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic void push_opener();
      push_text(mcs_pkg::CHAR_LT, 1'b0);
      push_text(mcs_pkg::CHAR_BANG, 1'b0);
      push_text(mcs_pkg::CHAR_DASH, 1'b0);
      push_text(mcs_pkg::CHAR_DASH, 1'b0);
   endfunction

   // appends one random piece of text, mostly well formed
   task automatic add_snippet();
      int kind;
      int len;
      int i;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) push_text(8'($urandom_range(32, 126)), 1'b0);
         end
         2, 3, 4: begin
            // a whole comment; kind 4 puts a failed close in the middle
            push_opener();
            len = $urandom_range(0, 5);
            for (i = 0; i < len; i++) push_text(comment_byte(), 1'b0);
            if (kind == 4) begin
               push_text(mcs_pkg::CHAR_DASH, 1'b0);
               push_text(mcs_pkg::CHAR_DASH, 1'b0);
               push_text(mcs_pkg::CHAR_DASH, 1'b0);
               push_text(mcs_pkg::CHAR_GT, 1'b0);
               push_text(comment_byte(), 1'b0);
            end
            push_text(mcs_pkg::CHAR_DASH, 1'b0);
            push_text(mcs_pkg::CHAR_DASH, 1'b0);
            push_text(mcs_pkg::CHAR_GT, 1'b0);
         end
         5: begin
            push_text(mcs_pkg::CHAR_LT, 1'b0);
            for (i = 0; i < 3; i++) push_text(near_miss_byte(), 1'b0);
         end
         6: begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) push_text(8'($urandom_range(0, 255)), 1'b0);
         end
         7: begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) push_text(8'($urandom_range(0, 31)), 1'b0);
         end
         8: begin
            // end of stream now and then, with a junk byte beside it
            if ($urandom_range(0, 2) == 0) push_text(8'($urandom_range(0, 255)), 1'b1);
            else push_text(8'($urandom_range(32, 126)), 1'b0);
         end
         default: begin
            push_text(mcs_pkg::CHAR_LT, 1'b0);
            push_text(mcs_pkg::CHAR_BANG, 1'b0);
            push_text(mcs_pkg::CHAR_DASH, 1'b0);
            push_text(near_miss_byte(), 1'b0);
         end
      endcase
   endtask

   // offers one beat, with random idle cycles first; starts and ends on a
   // falling edge, so each step sees one assignment to req_tvalid at most
   task automatic send_beat(input text_beat_type beat);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat.ch;
      req_tlast  <= beat.eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // sender pause until every expected beat has come out
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_n != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int n;
      int k;
      int phase;
      int prev_phase;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed text: byte extremes, cr/lf, dropped controls, holds
      push_text(8'hFF, 1'b0);                // top byte passes
      push_text(8'h00, 1'b0);                // control byte dropped
      push_text(mcs_pkg::CHAR_CR, 1'b0);     // becomes a space
      push_text(mcs_pkg::CHAR_LT, 1'b0);     // hold opens
      push_text(8'h01, 1'b0);                // dropped, not counted in the hold
      push_text(mcs_pkg::CHAR_LF, 1'b0);     // held as a space
      push_text(mcs_pkg::CHAR_LT, 1'b0);     // second '<' is just a held byte
      push_text(8'h62, 1'b0);                // hold fails, four beats out
      push_opener();                         // comment opens
      push_text(mcs_pkg::CHAR_DASH, 1'b0);   // "---" check fails, comment goes on
      push_text(mcs_pkg::CHAR_DASH, 1'b0);
      push_text(mcs_pkg::CHAR_DASH, 1'b0);
      push_text(mcs_pkg::CHAR_DASH, 1'b0);   // "-->" closes it
      push_text(mcs_pkg::CHAR_DASH, 1'b0);
      push_text(mcs_pkg::CHAR_GT, 1'b0);
      push_text(mcs_pkg::CHAR_LT, 1'b0);     // hold open outside a comment at the end
      push_text(mcs_pkg::CHAR_BANG, 1'b0);
      push_text(8'h00, 1'b1);                // flushes "<!" then the end marker
      push_opener();
      push_text(mcs_pkg::CHAR_DASH, 1'b0);   // close hold open inside a comment
      push_text(8'hFF, 1'b1);                // held bytes thrown away, end marker only
      foreach (text_q[i]) send_beat(text_q[i]);
      drain_outputs();

      // random text in four pressure phases
      text_q.delete();
      while (text_q.size() < ITEM_TARGET - 25) add_snippet();
      push_text(8'($urandom_range(0, 255)), 1'b1);
      n          = text_q.size();
      prev_phase = -1;
      for (k = 0; k < n; k++) begin
         phase = (k * 4) / n;
         if (phase != prev_phase) begin
            prev_phase = phase;
            case (phase)
               0: begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 0;
               end
               1: begin
                  drain_outputs();
                  send_idle_pct  = 48;
                  recv_stall_pct = 0;
               end
               2: begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 48;
               end
               default: begin
                  send_idle_pct  = 17;
                  recv_stall_pct = 17;
               end
            endcase
         end
         // long receiver hold-off while the sender keeps pushing
         if (k == n / 8) hold_off_req = 1'b1;
         send_beat(text_q[k]);
      end

      // wind down: everything out, then a few quiet cycles
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_n != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_n == 0) begin
         $display("tb_markup_comment_stripper: PASS");
      end else begin
         $display("tb_markup_comment_stripper: FAIL");
      end
      $finish;
   end

endmodule
